// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the gaze dwell tracker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons on the same edge
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// expr never holds
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// ante is followed on the next edge by cons
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gdat_pkg.sv =====
// Types and constants of the gaze dwell awareness tracker
package gdat_pkg;

  localparam int IDX_W   = 8;
  localparam int TIME_W  = 32;
  localparam int FRAME_W = 16;
  localparam int DWELL_W = 24;
  localparam int CFG_W   = 24;
  localparam int AWR_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int INDEX_SPAN = 2 ** IDX_W;

  // awareness codes
  localparam logic [AWR_W-1:0] ST_UNDET = 2'd0;
  localparam logic [AWR_W-1:0] ST_DET   = 2'd1;
  localparam logic [AWR_W-1:0] ST_COMP  = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_COMPREHEND_DWELL = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LOOK_AWAY        = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DETECTED_LIFE    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_COMPREHENDED_LIFE = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] comprehend_dwell;
    logic [CFG_W-1:0] look_away;
    logic [CFG_W-1:0] detected_life;
    logic [CFG_W-1:0] comprehended_life;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   object_index;
    logic [TIME_W-1:0]  now_ms;
    logic [FRAME_W-1:0] frame_ms;
    logic               gaze_hit;
    logic               oor;
  } item_t;

  typedef struct packed {
    logic [AWR_W-1:0]   st;
    logic [TIME_W-1:0]  bday;
    logic [TIME_W-1:0]  last;
    logic [DWELL_W-1:0] dwell;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EVAL_A,
    BK_EVAL_B,
    BK_COMMIT
  } bk_state_t;

endpackage

// ===== rtl/gaze_dwell_awareness_tracker_top.sv =====
// Gaze dwell awareness tracker: config registers, front end and back end
// An accepted word waits in the queue until the back end is idle, then is read,
// evaluated in two steps and committed on the single object table; commit stalls
// while a result is held unread. No new word is taken before that commit.
// Reset: config returns to defaults; the object table's min(NUM_OBJECTS, 256)
// entries are then cleared in a sweep, with in_ready low until the sweep ends.
module gaze_dwell_awareness_tracker_top import gdat_pkg::*; #(
  parameter int NUM_OBJECTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   object_index,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [FRAME_W-1:0] frame_ms,
  input  logic               gaze_hit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   echo_index,
  output logic [AWR_W-1:0]   awareness,
  output logic [DWELL_W-1:0] dwell_ms
);

  cfg_t       cfg;
  bk_status_t bk_status;
  logic       head_valid;
  item_t      head;
  logic       head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comprehend_dwell  <= CFG_W'(1000);
      cfg.look_away         <= CFG_W'(500);
      cfg.detected_life     <= CFG_W'(3000);
      cfg.comprehended_life <= CFG_W'(5000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPREHEND_DWELL:  cfg.comprehend_dwell  <= cfg_data;
        CFG_LOOK_AWAY:         cfg.look_away         <= cfg_data;
        CFG_DETECTED_LIFE:     cfg.detected_life     <= cfg_data;
        CFG_COMPREHENDED_LIFE: cfg.comprehended_life <= cfg_data;
        default: ;
      endcase
    end
  end

  gdat_front #(
    .NUM_OBJECTS (NUM_OBJECTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .object_index (object_index),
    .now_ms       (now_ms),
    .frame_ms     (frame_ms),
    .gaze_hit     (gaze_hit),
    .bk_status    (bk_status),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop)
  );

  gdat_back #(
    .NUM_OBJECTS (NUM_OBJECTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .bk_status  (bk_status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .echo_index (echo_index),
    .awareness  (awareness),
    .dwell_ms   (dwell_ms)
  );

endmodule

// ===== rtl/gdat_ram.sv =====
// Generic simple dual-port RAM with registered read
module gdat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gdat_front.sv =====
// Front end: input handshake, index range check and two-word queue
`include "assert_macros.svh"

module gdat_front import gdat_pkg::*; #(
  parameter int NUM_OBJECTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   object_index,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [FRAME_W-1:0] frame_ms,
  input  logic               gaze_hit,
  input  bk_status_t         bk_status,
  output logic               head_valid,
  output item_t              head,
  input  logic               head_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      in_item;

  assign in_ready   = (count != 2'd2) && !bk_status.clearing;
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_comb begin
    in_item.object_index = object_index;
    in_item.now_ms       = now_ms;
    in_item.frame_ms     = frame_ms;
    in_item.gaze_hit     = gaze_hit;
    in_item.oor          = (32'(object_index) >= 32'(NUM_OBJECTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (head_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(head_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk, rst, count == 2'd3, "queue count out of range")
  `ASSERT_NEVER(a_q_underflow, clk, rst, head_pop && (count == 2'd0), "pop from empty queue")
  `ASSERT_NEXT(a_q_head_hold, clk, rst, head_valid && !head_pop, head_valid && $stable(head), "queue head moved without pop")

endmodule

// ===== rtl/gdat_back.sv =====
// Back end: table clear, read-modify-write of one object entry, result register
`include "assert_macros.svh"

module gdat_back import gdat_pkg::*; #(
  parameter int NUM_OBJECTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                head_valid,
  input  item_t               head,
  output logic                head_pop,
  output bk_status_t          bk_status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    echo_index,
  output logic [AWR_W-1:0]    awareness,
  output logic [DWELL_W-1:0]  dwell_ms
);

  // only 2^IDX_W objects are addressable
  localparam int DEPTH = (NUM_OBJECTS < INDEX_SPAN) ? NUM_OBJECTS : INDEX_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bk_state_t state, state_next;
  logic [AW-1:0] clr_addr;
  item_t   work;
  entry_t  ent_a, ent_b;
  logic    away_a;
  logic [DWELL_W-1:0] sum_a;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic          commit_go;

  logic               away_next;
  logic [DWELL_W-1:0] sum_next;
  entry_t             ent_b_next;
  entry_t             ent_final;

  gdat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head.object_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign commit_go = (state == BK_COMMIT) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (head_valid) state_next = BK_EVAL_A;
      end
      BK_EVAL_A: state_next = BK_EVAL_B;
      BK_EVAL_B: state_next = BK_COMMIT;
      BK_COMMIT: begin
        if (commit_go) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    head_pop           = (state == BK_IDLE) && head_valid;
    bk_status.clearing = (state == BK_CLEAR);
    ram_we             = (state == BK_CLEAR) || (commit_go && !work.oor);
    ram_waddr          = (state == BK_CLEAR) ? clr_addr : work.object_index[AW-1:0];
    ram_wdata          = (state == BK_CLEAR) ? '0 : ent_final;
  end

  // stage A: look-away gap and saturating dwell sum, straight off the read word
  always_comb begin
    logic [TIME_W-1:0]  gap;
    logic [DWELL_W:0]   sum;
    gap       = work.now_ms - ram_rdata.last;
    away_next = gap > {{(TIME_W - CFG_W){1'b0}}, cfg.look_away};
    sum       = {1'b0, ram_rdata.dwell} + {{(DWELL_W + 1 - FRAME_W){1'b0}}, work.frame_ms};
    sum_next  = sum[DWELL_W] ? {DWELL_W{1'b1}} : sum[DWELL_W-1:0];
  end

  // stage B: hit handling and promotion
  always_comb begin
    ent_b_next = ent_a;
    if (work.gaze_hit) begin
      ent_b_next.dwell = away_a ? {{(DWELL_W - FRAME_W){1'b0}}, work.frame_ms} : sum_a;
      ent_b_next.last  = work.now_ms;
      if (ent_a.st == ST_UNDET) begin
        ent_b_next.st   = ST_DET;
        ent_b_next.bday = work.now_ms;
      end
      if (ent_b_next.dwell >= cfg.comprehend_dwell) begin
        ent_b_next.st   = ST_COMP;
        ent_b_next.bday = work.now_ms;
      end
    end
  end

  // commit: lifetime demotion
  always_comb begin
    logic [TIME_W-1:0] age;
    age       = work.now_ms - ent_b.bday;
    ent_final = ent_b;
    if ((ent_b.st == ST_DET) && (age > {{(TIME_W - CFG_W){1'b0}}, cfg.detected_life})) begin
      ent_final.st    = ST_UNDET;
      ent_final.bday  = '0;
      ent_final.dwell = '0;
    end else if ((ent_b.st == ST_COMP) &&
                 (age > {{(TIME_W - CFG_W){1'b0}}, cfg.comprehended_life})) begin
      ent_final.st    = ST_DET;
      ent_final.bday  = work.now_ms;
      ent_final.dwell = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (commit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      work <= head;
    end
    if (state == BK_EVAL_A) begin
      ent_a  <= ram_rdata;
      away_a <= away_next;
      sum_a  <= sum_next;
    end
    if (state == BK_EVAL_B) begin
      ent_b <= ent_b_next;
    end
    if (commit_go) begin
      echo_index <= work.object_index;
      awareness  <= work.oor ? ST_UNDET : ent_final.st;
      dwell_ms   <= work.oor ? '0 : ent_final.dwell;
    end
  end

  `ASSERT_IMPL(a_we_state, clk, rst, ram_we, (state == BK_CLEAR) || (state == BK_COMMIT), "table write outside clear or commit")
  `ASSERT_IMPL(a_out_from_commit, clk, rst, $rose(out_valid), $past(state) == BK_COMMIT, "result raised without commit")
  `ASSERT_NEVER(a_oor_write, clk, rst, ram_we && (state == BK_COMMIT) && work.oor, "write for index beyond table")
  `ASSERT_NEVER(a_pop_clearing, clk, rst, head_pop && bk_status.clearing, "item taken during table clear")

endmodule
